// File: rtl/core/bdeht_pkg.sv
// Shared widths, constants and types of the button debouncer with hold timers.
`default_nettype none

package bdeht_pkg;

    // Fixed widths of the item fields.
    localparam int MASK_W   = 5;
    localparam int TIME_W   = 32;
    localparam int SETTLE_W = 16;

    // Settle time after reset, in milliseconds.
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd20;

    // Per-button control from the debounce logic into one hold-timer lane.
    typedef struct packed {
        logic deb;   // Debounced state of the button after this item.
        logic rise;  // Button became pressed at this item.
        logic fall;  // Button became released at this item.
    } t_lane_ctl;

    // One result item as it sits in the output buffer.
    typedef struct packed {
        logic [MASK_W-1:0]             stable;
        logic [MASK_W-1:0]             pressed;
        logic [MASK_W-1:0]             released;
        logic [MASK_W-1:0][TIME_W-1:0] held;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/bdeht_lane.sv
// One hold-timer lane: press start time and held duration of a single button.
`default_nettype none

module bdeht_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire bdeht_pkg::t_lane_ctl         i_ctl,
    input  wire logic [bdeht_pkg::TIME_W-1:0] i_now,
    output logic      [bdeht_pkg::TIME_W-1:0] o_held
);

    logic [bdeht_pkg::TIME_W-1:0] r_press_start;
    logic [bdeht_pkg::TIME_W-1:0] n_press_start;

    always_comb begin
        priority if (i_ctl.rise) begin
            n_press_start = i_now;
        end else if (i_ctl.fall) begin
            n_press_start = '0;
        end else begin
            n_press_start = r_press_start;
        end
    end

    // A fresh press reports zero: the rise forces the output to zero while the current time is recorded as the start.
    assign o_held = (i_ctl.deb && !i_ctl.rise) ? (i_now - r_press_start) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start <= '0;
        end else if (i_accept) begin
            r_press_start <= n_press_start;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bdeht_outbuf.sv
// Two-entry output buffer that decouples result delivery from item intake.
`default_nettype none

module bdeht_outbuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bdeht_pkg::t_result i_data,
    output logic                    o_not_full,
    output logic                    o_valid,
    input  wire logic               i_pop_ready,
    output bdeht_pkg::t_result      o_data
);

    bdeht_pkg::t_result r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               pop;

    assign o_not_full = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid && i_pop_ready;
    assign o_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_edge_hold_timer.sv
// Top level of the timestamped button debouncer with edge detection and hold timers.
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ----------------------------------------
//  in       input      i_in_valid / o_in_ready    i_raw_buttons, i_now_time_ms
//  out      output     o_out_valid / i_out_ready  o_stable_buttons, o_pressed_edges,
//                                                 o_released_edges, o_held_time_0..4
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (settle time in ms)
//
// Each item is processed in the cycle it is accepted and its result is written into the
// output buffer; one item per cycle is sustained while the buffer has room. The rate is
// set by the combinational debounce compare and the per-button hold-timer subtractors.
// Reset (synchronous, active low) clears all masks and times and sets the settle time
// to 20 ms. A two-entry output buffer lets intake continue while one result waits; input
// stalls only when two results are waiting. The configuration port is always ready.
`default_nettype none

module button_debounce_edge_hold_timer #(
    parameter int BUTTONS = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [bdeht_pkg::MASK_W-1:0]   i_raw_buttons,
    input  wire logic [bdeht_pkg::TIME_W-1:0]   i_now_time_ms,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [bdeht_pkg::MASK_W-1:0]   o_stable_buttons,
    output logic      [bdeht_pkg::MASK_W-1:0]   o_pressed_edges,
    output logic      [bdeht_pkg::MASK_W-1:0]   o_released_edges,
    output logic      [bdeht_pkg::TIME_W-1:0]   o_held_time_0,
    output logic      [bdeht_pkg::TIME_W-1:0]   o_held_time_1,
    output logic      [bdeht_pkg::TIME_W-1:0]   o_held_time_2,
    output logic      [bdeht_pkg::TIME_W-1:0]   o_held_time_3,
    output logic      [bdeht_pkg::TIME_W-1:0]   o_held_time_4,

    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bdeht_pkg::SETTLE_W-1:0] i_cfg_data
);

    // Raw bits at or above BUTTONS are treated as not pressed.
    localparam logic [bdeht_pkg::MASK_W-1:0] BtnMask =
        bdeht_pkg::MASK_W'((1 << BUTTONS) - 1);

    logic [bdeht_pkg::SETTLE_W-1:0] r_settle;
    logic [bdeht_pkg::MASK_W-1:0]   r_last_raw;
    logic [bdeht_pkg::MASK_W-1:0]   n_last_raw;
    logic [bdeht_pkg::TIME_W-1:0]   r_last_change;
    logic [bdeht_pkg::TIME_W-1:0]   n_last_change;
    logic [bdeht_pkg::MASK_W-1:0]   r_debounced;
    logic [bdeht_pkg::MASK_W-1:0]   n_debounced;

    logic [bdeht_pkg::MASK_W-1:0]   raw_masked;
    logic                           raw_changed;
    logic [bdeht_pkg::TIME_W-1:0]   elapsed;
    logic [bdeht_pkg::MASK_W-1:0]   rise;
    logic [bdeht_pkg::MASK_W-1:0]   fall;
    logic                           in_accept;
    logic                           buf_not_full;

    bdeht_pkg::t_lane_ctl           lane_ctl  [bdeht_pkg::MASK_W];
    logic [bdeht_pkg::MASK_W-1:0][bdeht_pkg::TIME_W-1:0] lane_held;
    bdeht_pkg::t_result             result_in;
    bdeht_pkg::t_result             result_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = buf_not_full;
    assign in_accept   = i_in_valid && o_in_ready;

    // Debounce: a raw change restarts the settle window at the current time, and the
    // whole debounced mask follows the recorded raw mask once the window has passed.
    // When the raw mask changes at this item the elapsed time is zero, so only a zero
    // settle time lets the change through at once.
    always_comb begin
        raw_masked    = i_raw_buttons & BtnMask;
        raw_changed   = (raw_masked != r_last_raw);
        n_last_raw    = raw_changed ? raw_masked : r_last_raw;
        n_last_change = raw_changed ? i_now_time_ms : r_last_change;
        elapsed       = i_now_time_ms - n_last_change;
        if ((r_debounced != n_last_raw) &&
            (elapsed >= {{(bdeht_pkg::TIME_W-bdeht_pkg::SETTLE_W){1'b0}}, r_settle})) begin
            n_debounced = n_last_raw;
        end else begin
            n_debounced = r_debounced;
        end
        // The previous debounced mask is exactly the current register value.
        rise = n_debounced & ~r_debounced;
        fall = r_debounced & ~n_debounced;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle      <= bdeht_pkg::SETTLE_RESET;
            r_last_raw    <= '0;
            r_last_change <= '0;
            r_debounced   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_settle <= i_cfg_data;
            end
            if (in_accept) begin
                r_last_raw    <= n_last_raw;
                r_last_change <= n_last_change;
                r_debounced   <= n_debounced;
            end
        end
    end

    // One hold-timer lane per configured button; the others always report zero.
    for (genvar g = 0; g < bdeht_pkg::MASK_W; g++) begin : g_lane
        assign lane_ctl[g] = '{deb: n_debounced[g], rise: rise[g], fall: fall[g]};
        if (g < BUTTONS) begin : g_used
            bdeht_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_accept (in_accept),
                .i_ctl    (lane_ctl[g]),
                .i_now    (i_now_time_ms),
                .o_held   (lane_held[g])
            );
        end else begin : g_unused
            assign lane_held[g] = '0;
        end
    end

    // Merge the masks and the lane results into one result item.
    assign result_in = '{
        stable:   n_debounced,
        pressed:  rise,
        released: fall,
        held:     lane_held
    };

    bdeht_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_data      (result_in),
        .o_not_full  (buf_not_full),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (result_out)
    );

    assign o_stable_buttons = result_out.stable;
    assign o_pressed_edges  = result_out.pressed;
    assign o_released_edges = result_out.released;
    assign o_held_time_0    = result_out.held[0];
    assign o_held_time_1    = result_out.held[1];
    assign o_held_time_2    = result_out.held[2];
    assign o_held_time_3    = result_out.held[3];
    assign o_held_time_4    = result_out.held[4];

    // A delivered press edge always belongs to a button that is now stable pressed.
    a_press_in_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_edges & ~o_stable_buttons) == '0))
        else $error("pressed edge reported for a button that is not stable pressed");

    // A delivered release edge always belongs to a button that is now released.
    a_release_not_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_released_edges & o_stable_buttons) == '0))
        else $error("released edge reported for a button that is still pressed");

    // Button 0, when it is not pressed, reports no held time.
    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_stable_buttons[0]) |-> (o_held_time_0 == '0))
        else $error("held time of a released button is not zero");

    // The debounced state moves only when an item is accepted.
    a_deb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_debounced))
        else $error("debounced mask changed without an accepted item");

endmodule

`default_nettype wire
